>>> rtl/pctd_pkg.sv
// Shared types and constants for the prime counting trial division unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package pctd_pkg;

   // opcode codes
   localparam logic OP_COUNT_UPTO = 1'b0;
   localparam logic OP_PRIME_DIVS = 1'b1;

   // smallest prime, first odd trial divisor, stride between odd values
   localparam int FIRST_PRIME = 2;
   localparam int FIRST_TRIAL = 3;
   localparam int TRIAL_STEP  = 2;

   // controller -> datapath commands; several may be set in one cycle
   typedef struct packed {
      logic load;        // capture request beat, clear count
      logic cand_first;  // value <= first odd candidate
      logic cand_next;   // value <= value + 2
      logic halve;       // value <= value >> 1
      logic take_quot;   // value <= quotient, mark divisor as counted
      logic count_inc;   // count <= count + 1
      logic trial_first; // divisor <= 3, square <= 9
      logic trial_next;  // divisor <= divisor + 2, square updated
      logic div_start;   // launch divider on value / divisor
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic op;
      logic lim_lt2;
      logic val_even;
      logic val_over_lim;
      logic sq_le_val;
      logic val_gt1;
      logic div_done;
      logic rem_zero;
      logic hit;
   } status_type;

endpackage

>>> rtl/pctd_divider.sv
// Radix-4 restoring divider: two quotient bits per cycle, quotient and remainder.
// Standalone; instantiated by pctd_datapath.
module pctd_divider #(
   parameter int W = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int STEPS = (W + 1) / 2;
   localparam int PW    = 2 * STEPS;
   localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  div_ff, div_in;

   logic [W:0]    t1, t2, r1, r2;
   logic          ge1, ge2;

   always_comb begin
      t1  = {rem_ff, quo_ff[PW-1]};
      ge1 = t1 >= {1'b0, div_ff};
      r1  = ge1 ? t1 - {1'b0, div_ff} : t1;
      t2  = {r1[W-1:0], quo_ff[PW-2]};
      ge2 = t2 >= {1'b0, div_ff};
      r2  = ge2 ? t2 - {1'b0, div_ff} : t2;
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         quo_in    = PW'(dividend);
         rem_in    = '0;
         div_in    = divisor;
      end else if (active_ff) begin
         cnt_in = cnt_ff + CW'(1);
         quo_in = {quo_ff[PW-3:0], ge1, ge2};
         rem_in = r2[W-1:0];
         if (cnt_ff == CW'(STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[W-1:0];
   assign remainder = rem_ff;

endmodule

>>> rtl/pctd_datapath.sv
// Datapath: operand, candidate, trial divisor and its square, count, and the divider.
// Depends on pctd_pkg and pctd_divider; driven by pctd_ctrl commands.
module pctd_datapath #(
   parameter int W = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pctd_pkg::cmd_type      cmd,
   input  logic                   req_opcode,
   input  logic [W-1:0]           req_number,
   output pctd_pkg::status_type   status,
   output logic [W-1:0]           rsp_count,
   output logic                   rsp_kind
);

   logic         op_ff, op_in;
   logic [W-1:0] lim_ff, lim_in;
   logic [W:0]   val_ff, val_in;    // candidate may step past the limit
   logic [W-1:0] d_ff, d_in;
   logic [W+1:0] sq_ff, sq_in;      // d*d, kept by increments
   logic         hit_ff, hit_in;
   logic [W-1:0] count_ff, count_in;

   logic         div_done;
   logic [W-1:0] quotient;
   logic [W-1:0] remainder;

   pctd_divider #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (val_ff[W-1:0]),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      op_in    = op_ff;
      lim_in   = lim_ff;
      val_in   = val_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      hit_in   = hit_ff;
      count_in = count_ff;
      if (cmd.load) begin
         op_in    = req_opcode;
         lim_in   = req_number;
         val_in   = {1'b0, req_number};
         count_in = '0;
      end
      if (cmd.cand_first) val_in = (W+1)'(pctd_pkg::FIRST_TRIAL);
      if (cmd.cand_next)  val_in = val_ff + (W+1)'(pctd_pkg::TRIAL_STEP);
      if (cmd.halve)      val_in = val_ff >> 1;
      if (cmd.take_quot) begin
         val_in = {1'b0, quotient};
         hit_in = 1'b1;
      end
      if (cmd.count_inc) count_in = count_ff + W'(1);
      if (cmd.trial_first) begin
         d_in   = W'(pctd_pkg::FIRST_TRIAL);
         sq_in  = (W+2)'(pctd_pkg::FIRST_TRIAL * pctd_pkg::FIRST_TRIAL);
         hit_in = 1'b0;
      end
      if (cmd.trial_next) begin
         d_in   = d_ff + W'(pctd_pkg::TRIAL_STEP);
         // (d+2)^2 = d^2 + 4d + 4
         sq_in  = sq_ff + {d_ff, 2'b00} + (W+2)'(pctd_pkg::TRIAL_STEP * pctd_pkg::TRIAL_STEP);
         hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      lim_ff   <= lim_in;
      val_ff   <= val_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      hit_ff   <= hit_in;
      count_ff <= count_in;
   end

   always_comb begin
      status.op           = op_ff;
      status.lim_lt2      = lim_ff < W'(pctd_pkg::FIRST_PRIME);
      status.val_even     = ~val_ff[0];
      status.val_over_lim = val_ff > {1'b0, lim_ff};
      status.sq_le_val    = sq_ff <= {1'b0, val_ff};
      status.val_gt1      = val_ff > (W+1)'(1);
      status.div_done     = div_done;
      status.rem_zero     = remainder == '0;
      status.hit          = hit_ff;
   end

   assign rsp_count = count_ff;
   assign rsp_kind  = op_ff;

   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.trial_first || cmd.trial_next) |-> d_ff[0])
      else $error("trial divisor went even");

   a_square_tracks: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.trial_first || cmd.trial_next) |->
         (2*W)'(sq_ff) == (2*W)'(d_ff) * (2*W)'(d_ff))
      else $error("square register out of step with divisor");

endmodule

>>> rtl/pctd_ctrl.sv
// Controller state machine: sequences candidates, trial divisors and divisions.
// Depends on pctd_pkg; talks to pctd_datapath through command and status structs.
module pctd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pctd_pkg::status_type status,
   output pctd_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SETUP = 8'b0000_0010,
      S_HALVE = 8'b0000_0100,
      S_CAND  = 8'b0000_1000,
      S_CHECK = 8'b0001_0000,
      S_DIV   = 8'b0010_0000,
      S_REDIV = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (status.lim_lt2) begin
               state_in = S_DONE;
            end else if (status.op == pctd_pkg::OP_COUNT_UPTO) begin
               // 2 counted up front, then odd candidates only
               cmd.count_inc  = 1'b1;
               cmd.cand_first = 1'b1;
               state_in       = S_CAND;
            end else begin
               cmd.count_inc = status.val_even;
               state_in      = S_HALVE;
            end
         end
         S_HALVE: begin
            if (status.val_even) begin
               cmd.halve = 1'b1;
            end else begin
               cmd.trial_first = 1'b1;
               state_in        = S_CHECK;
            end
         end
         S_CAND: begin
            if (status.val_over_lim) begin
               state_in = S_DONE;
            end else begin
               cmd.trial_first = 1'b1;
               state_in        = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.sq_le_val) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.op == pctd_pkg::OP_COUNT_UPTO) begin
               // no divisor up to the root: candidate is prime
               cmd.count_inc = 1'b1;
               cmd.cand_next = 1'b1;
               state_in      = S_CAND;
            end else begin
               // leftover cofactor above 1 is a prime
               cmd.count_inc = status.val_gt1;
               state_in      = S_DONE;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               if (!status.rem_zero) begin
                  cmd.trial_next = 1'b1;
                  state_in       = S_CHECK;
               end else if (status.op == pctd_pkg::OP_COUNT_UPTO) begin
                  cmd.cand_next = 1'b1;
                  state_in      = S_CAND;
               end else begin
                  // divide this factor out fully, count it once
                  cmd.take_quot = 1'b1;
                  cmd.count_inc = ~status.hit;
                  state_in      = S_REDIV;
               end
            end
         end
         S_REDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;

   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == S_SETUP)
      else $error("accepted beat did not enter setup");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == S_DIV)
      else $error("divider finished while controller not waiting");

endmodule

>>> rtl/prime_count_trial_division_unit.sv
// Prime counting by trial division. Opcode 0 counts primes in 2..number, opcode 1
// counts distinct prime divisors. One item at a time; busy stays high until done.
// Each trial division runs in the shared radix-4 divider; opcode 0 repeats the trial
// divisions for every odd candidate up to number. Result strobe lasts one cycle;
// the receiver cannot stall.
// Reset is synchronous and returns the controller and divider to idle; no clearing pass.
module prime_count_trial_division_unit #(
   parameter int NUMBER_WIDTH = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_opcode,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_strobe,
   output logic [NUMBER_WIDTH-1:0] rsp_count,
   output logic                    rsp_kind
);

   pctd_pkg::cmd_type    cmd;
   pctd_pkg::status_type status;

   pctd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pctd_datapath #(.W(NUMBER_WIDTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_opcode (req_opcode),
      .req_number (req_number),
      .status     (status),
      .rsp_count  (rsp_count),
      .rsp_kind   (rsp_kind)
   );

endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for prime_count_trial_division_unit: directed and random beats,
// expected counts from a local sieve and a local factorizer. Depends on rtl/pctd_pkg.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_W       = 20;
   localparam int SIEVE_SPAN  = 4096;     // opcode 0 operands stay below this
   localparam int SIEVE_IW    = $clog2(SIEVE_SPAN);
   localparam int STALL_LIMIT = 3000000;
   localparam int GAP_PCT     = 8;

   typedef struct {
      logic             op;
      logic [NUM_W-1:0] num;
      bit               drain;  // hold this beat until every count is back
      bit               calm;   // no random gap before this beat
   } job_type;

   typedef struct {
      logic [NUM_W-1:0] count;
      logic             kind;
   } answer_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_opcode;
   logic [NUM_W-1:0] req_number;
   logic             rsp_strobe;
   logic [NUM_W-1:0] rsp_count;
   logic             rsp_kind;

   job_type          jobs[$];
   answer_type       answers[$];
   bit               is_prime[SIEVE_SPAN];
   logic [NUM_W-1:0] primes_upto[SIEVE_SPAN];
   int               errors;
   bit               beat_taken;
   int               stall_cycles;

   prime_count_trial_division_unit #(.NUMBER_WIDTH(NUM_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_number (req_number),
      .rsp_strobe (rsp_strobe),
      .rsp_count  (rsp_count),
      .rsp_kind   (rsp_kind)
   );

   function automatic int unsigned distinct_prime_factors(int unsigned n);
      int unsigned rest;
      int unsigned d;
      int unsigned found;
      rest  = n;
      found = 0;
      if (rest < 2)
         return 0;
      if (rest % 2 == 0) begin
         found++;
         while (rest % 2 == 0)
            rest = rest / 2;
      end
      for (d = 3; d * d <= rest; d += 2) begin
         if (rest % d == 0) begin
            found++;
            while (rest % d == 0)
               rest = rest / d;
         end
      end
      if (rest > 1)
         found++;
      return found;
   endfunction

   function automatic bit prime_by_trial(int unsigned n);
      int unsigned d;
      if (n < pctd_pkg::FIRST_PRIME)
         return 1'b0;
      if (n % 2 == 0)
         return n == pctd_pkg::FIRST_PRIME;
      for (d = 3; d * d <= n; d += 2)
         if (n % d == 0)
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic answer_type predict_count(logic op, logic [NUM_W-1:0] num);
      answer_type  a;
      int unsigned k;
      int unsigned tally;
      a.kind = op;
      if (op == pctd_pkg::OP_COUNT_UPTO) begin
         if (num < SIEVE_SPAN) begin
            a.count = primes_upto[num[SIEVE_IW-1:0]];
         end else begin
            // beyond the sieve: count directly
            tally = 0;
            for (k = 0; k <= num; k++)
               if (prime_by_trial(k))
                  tally++;
            a.count = NUM_W'(tally);
         end
      end else begin
         a.count = NUM_W'(distinct_prime_factors(num));
      end
      return a;
   endfunction

   task automatic add_job(logic op, int unsigned num, bit drain = 0, bit calm = 0);
      job_type j;
      j.op    = op;
      j.num   = num[NUM_W-1:0];
      j.drain = drain;
      j.calm  = calm;
      jobs.push_back(j);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver: a beat stays on the ports until the block takes it
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (jobs.size() == 0) begin
            start <= 1'b0;
         end else if (jobs[0].drain && answers.size() != 0) begin
            start <= 1'b0;
         end else if (!jobs[0].calm && $urandom_range(0, 99) < GAP_PCT) begin
            start <= 1'b0;
         end else begin
            start      <= 1'b1;
            req_opcode <= jobs[0].op;
            req_number <= jobs[0].num;
            jobs.delete(0);
         end
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         beat_taken   <= 1'b0;
         stall_cycles <= 0;
      end else begin
         beat_taken <= start && !busy;
         if (rsp_strobe) begin
            if (answers.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual count %0d kind %0d",
                        $time, rsp_count, rsp_kind);
               errors++;
            end else begin
               want = answers.pop_front();
               if (rsp_count !== want.count) begin
                  $display("%0t: count mismatch, expected %0d, actual %0d",
                           $time, want.count, rsp_count);
                  errors++;
               end
               if (rsp_kind !== want.kind) begin
                  $display("%0t: kind mismatch, expected %0d, actual %0d",
                           $time, want.kind, rsp_kind);
                  errors++;
               end
            end
         end
         if (start && !busy)
            answers.push_back(predict_count(req_opcode, req_number));
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int i;
      int j;
      int tally;
      logic op;
      int unsigned n;

      start      = 1'b0;
      req_opcode = pctd_pkg::OP_COUNT_UPTO;
      req_number = '0;
      reset      = 1'b1;
      errors     = 0;

      for (i = 0; i < SIEVE_SPAN; i++)
         is_prime[i] = (i >= pctd_pkg::FIRST_PRIME);
      for (i = pctd_pkg::FIRST_PRIME; i * i < SIEVE_SPAN; i++)
         if (is_prime[i])
            for (j = i * i; j < SIEVE_SPAN; j += i)
               is_prime[j] = 1'b0;
      tally = 0;
      for (i = 0; i < SIEVE_SPAN; i++) begin
         if (is_prime[i])
            tally++;
         primes_upto[i] = NUM_W'(tally);
      end

      // zero and one give nothing for either operation
      add_job(pctd_pkg::OP_COUNT_UPTO, 0);
      add_job(pctd_pkg::OP_COUNT_UPTO, 1);
      add_job(pctd_pkg::OP_PRIME_DIVS, 0);
      add_job(pctd_pkg::OP_PRIME_DIVS, 1);
      add_job(pctd_pkg::OP_COUNT_UPTO, 2);
      add_job(pctd_pkg::OP_COUNT_UPTO, 3);
      add_job(pctd_pkg::OP_COUNT_UPTO, 4);
      add_job(pctd_pkg::OP_COUNT_UPTO, 9);
      add_job(pctd_pkg::OP_COUNT_UPTO, 100);
      add_job(pctd_pkg::OP_PRIME_DIVS, 2);
      add_job(pctd_pkg::OP_PRIME_DIVS, 3);
      add_job(pctd_pkg::OP_PRIME_DIVS, 4);
      add_job(pctd_pkg::OP_PRIME_DIVS, 12);            // repeated factor counts once
      add_job(pctd_pkg::OP_PRIME_DIVS, 961);           // square of a prime
      add_job(pctd_pkg::OP_PRIME_DIVS, 524288);        // power of two, top bit only
      add_job(pctd_pkg::OP_PRIME_DIVS, 510510);        // seven smallest primes
      add_job(pctd_pkg::OP_PRIME_DIVS, 999983);
      add_job(pctd_pkg::OP_PRIME_DIVS, 1048573);
      add_job(pctd_pkg::OP_PRIME_DIVS, (1 << NUM_W) - 1, 1);
      add_job(pctd_pkg::OP_COUNT_UPTO, 2047);
      add_job(pctd_pkg::OP_COUNT_UPTO, SIEVE_SPAN - 1);

      for (i = 0; i < 100; i++) begin
         op = 1'($urandom_range(0, 1));
         if (op == pctd_pkg::OP_COUNT_UPTO) begin
            // counting up to n is far slower than factoring it, keep n modest
            if ($urandom_range(0, 7) == 0)
               n = $urandom_range(256, 1023);
            else
               n = $urandom_range(0, 255);
         end else begin
            case ($urandom_range(0, 3))
               0, 1: n = $urandom_range(0, (1 << NUM_W) - 1);
               2: n = $urandom_range(0, 255);
               default: n = $urandom_range(1, 63) << $urandom_range(0, 14);
            endcase
         end
         add_job(op, n, (i == 0) || (i == 60), (i >= 20) && (i < 50));
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (jobs.size() != 0 || start)
         @(posedge clock);
      while (answers.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
